### sv/rgf_pkg.sv
// rgf_pkg: shared types, widths, block kind codes and the reciprocal table
// for the rectangle gradient fill. No dependencies.
package rgf_pkg;

    localparam int KIND_W      = 2;
    localparam int GRAY_W      = 8;
    localparam int EXT_W       = 3;
    localparam int DEN_W       = 6;
    localparam int NUM_W       = 14;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;

    localparam logic [KIND_W-1:0] KIND_RECT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HSEG = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VSEG = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DOT  = 2'd3;

    // Block normalized to the bilinear form, with incremental numerator terms
    typedef struct packed {
        logic [EXT_W-1:0]   ext_x;
        logic [EXT_W-1:0]   ext_y;
        logic [GRAY_W-1:0]  gray_a;
        logic [GRAY_W-1:0]  gray_b;
        logic [GRAY_W-1:0]  gray_c;
        logic [GRAY_W-1:0]  gray_d;
        logic [NUM_W-1:0]   num_base;
        logic [NUM_W-1:0]   col_step;
        logic [NUM_W-1:0]   row_step;
        logic [NUM_W-1:0]   row_delta;
        logic [RECIP_W-1:0] recip;
    } rgf_desc_t;

    // ceil(2^RECIP_SHIFT / den) for every product of two runs in 1..7
    function automatic logic [RECIP_W-1:0] recip_of(input logic [DEN_W-1:0] den);
        logic [RECIP_W-1:0] r;
        unique case (den)
            6'd1:    r = 21'd1048576;
            6'd2:    r = 21'd524288;
            6'd3:    r = 21'd349526;
            6'd4:    r = 21'd262144;
            6'd5:    r = 21'd209716;
            6'd6:    r = 21'd174763;
            6'd7:    r = 21'd149797;
            6'd8:    r = 21'd131072;
            6'd9:    r = 21'd116509;
            6'd10:   r = 21'd104858;
            6'd12:   r = 21'd87382;
            6'd14:   r = 21'd74899;
            6'd15:   r = 21'd69906;
            6'd16:   r = 21'd65536;
            6'd18:   r = 21'd58255;
            6'd20:   r = 21'd52429;
            6'd21:   r = 21'd49933;
            6'd24:   r = 21'd43691;
            6'd25:   r = 21'd41944;
            6'd28:   r = 21'd37450;
            6'd30:   r = 21'd34953;
            6'd35:   r = 21'd29960;
            6'd36:   r = 21'd29128;
            6'd42:   r = 21'd24967;
            6'd49:   r = 21'd21400;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### sv/rgf_blk_if.sv
// rgf_blk_if: valid/ready channel carrying one decoded block.
// Depends on rgf_pkg.
interface rgf_blk_if
    import rgf_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     block_kind;
    logic [GRAY_W-1:0]     gray_a;
    logic [GRAY_W-1:0]     gray_b;
    logic [GRAY_W-1:0]     gray_c;
    logic [GRAY_W-1:0]     gray_d;
    logic [COORD_BITS-1:0] left_x;
    logic [COORD_BITS-1:0] top_y;
    logic [EXT_W-1:0]      extent_x;
    logic [EXT_W-1:0]      extent_y;

    modport source (
        output valid, block_kind, gray_a, gray_b, gray_c, gray_d,
               left_x, top_y, extent_x, extent_y,
        input  ready
    );
    modport sink (
        input  valid, block_kind, gray_a, gray_b, gray_c, gray_d,
               left_x, top_y, extent_x, extent_y,
        output ready
    );
endinterface

### sv/rgf_pix_if.sv
// rgf_pix_if: valid/ready channel carrying one pixel write.
// Depends on rgf_pkg.
interface rgf_pix_if
    import rgf_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [GRAY_W-1:0]     pixel_value;
    logic                  last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_value, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_value, last_pixel,
        output ready
    );
endinterface

### sv/rgf_front.sv
// rgf_front: accepts blocks, maps every kind onto the bilinear form and
// precomputes the incremental numerator terms. Depends on rgf_pkg, rgf_blk_if.
module rgf_front
    import rgf_pkg::*;
#(
    parameter int MAX_EXTENT = 8,
    parameter int COORD_BITS = 12
)(
    input  logic                  clk,
    input  logic                  rst_n,
    rgf_blk_if.sink               blk,
    output logic                  push_valid,
    input  logic                  push_ready,
    output rgf_desc_t             push_desc,
    output logic [COORD_BITS-1:0] push_x0,
    output logic [COORD_BITS-1:0] push_y0
);

    localparam logic [EXT_W-1:0] EXT_LIM =
        (MAX_EXTENT - 1 > (1 << EXT_W) - 1) ? EXT_W'((1 << EXT_W) - 1)
                                            : EXT_W'(MAX_EXTENT - 1);

    logic                  s1_valid_reg, s1_valid_next;
    logic [GRAY_W-1:0]     ga_reg, gb_reg, gc_reg, gd_reg;
    logic [GRAY_W-1:0]     ga_next, gb_next, gc_next, gd_next;
    logic [EXT_W-1:0]      ex_reg, ey_reg, ex_next, ey_next;
    logic [EXT_W-1:0]      rx_reg, ry_reg, rx_next, ry_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [COORD_BITS-1:0] x0_reg, y0_reg;
    logic [EXT_W-1:0]      ex_clamp, ey_clamp;
    logic                  take;

    assign blk.ready = !s1_valid_reg || push_ready;
    assign take      = blk.valid && blk.ready;

    always_comb
    begin
        ex_clamp = (blk.extent_x > EXT_LIM) ? EXT_LIM : blk.extent_x;
        ey_clamp = (blk.extent_y > EXT_LIM) ? EXT_LIM : blk.extent_y;
        unique case (blk.block_kind)
            KIND_RECT:
            begin
                ga_next = blk.gray_a;
                gb_next = blk.gray_b;
                gc_next = blk.gray_c;
                gd_next = blk.gray_d;
                ex_next = ex_clamp;
                ey_next = ey_clamp;
            end
            KIND_HSEG:
            begin
                ga_next = blk.gray_a;
                gb_next = blk.gray_b;
                gc_next = blk.gray_a;
                gd_next = blk.gray_b;
                ex_next = ex_clamp;
                ey_next = '0;
            end
            KIND_VSEG:
            begin
                ga_next = blk.gray_a;
                gb_next = blk.gray_a;
                gc_next = blk.gray_b;
                gd_next = blk.gray_b;
                ex_next = '0;
                ey_next = ey_clamp;
            end
            KIND_DOT:
            begin
                ga_next = blk.gray_a;
                gb_next = blk.gray_a;
                gc_next = blk.gray_a;
                gd_next = blk.gray_a;
                ex_next = '0;
                ey_next = '0;
            end
            default:
            begin
                ga_next = blk.gray_a;
                gb_next = blk.gray_b;
                gc_next = blk.gray_c;
                gd_next = blk.gray_d;
                ex_next = ex_clamp;
                ey_next = ey_clamp;
            end
        endcase
        // zero extent runs as a span of one with fraction zero
        rx_next  = (ex_next == '0) ? EXT_W'(1) : ex_next;
        ry_next  = (ey_next == '0) ? EXT_W'(1) : ey_next;
        den_next = DEN_W'(rx_next) * DEN_W'(ry_next);
        s1_valid_next = take ? 1'b1 : (push_ready ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ga_reg  <= ga_next;
            gb_reg  <= gb_next;
            gc_reg  <= gc_next;
            gd_reg  <= gd_next;
            ex_reg  <= ex_next;
            ey_reg  <= ey_next;
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            den_reg <= den_next;
            x0_reg  <= blk.left_x;
            y0_reg  <= blk.top_y;
        end
    end

    // N(kx,ky) = N0 + kx*col_step + ky*(row_step + kx*row_delta), mod 2^NUM_W
    always_comb
    begin
        push_desc.ext_x     = ex_reg;
        push_desc.ext_y     = ey_reg;
        push_desc.gray_a    = ga_reg;
        push_desc.gray_b    = gb_reg;
        push_desc.gray_c    = gc_reg;
        push_desc.gray_d    = gd_reg;
        push_desc.num_base  = NUM_W'(NUM_W'(ga_reg) * NUM_W'(den_reg));
        push_desc.col_step  = NUM_W'((NUM_W'(gb_reg) - NUM_W'(ga_reg)) * NUM_W'(ry_reg));
        push_desc.row_step  = NUM_W'((NUM_W'(gc_reg) - NUM_W'(ga_reg)) * NUM_W'(rx_reg));
        push_desc.row_delta = (NUM_W'(gd_reg) - NUM_W'(gb_reg))
                            - (NUM_W'(gc_reg) - NUM_W'(ga_reg));
        push_desc.recip     = recip_of(den_reg);
    end

    assign push_valid = s1_valid_reg;
    assign push_x0    = x0_reg;
    assign push_y0    = y0_reg;

endmodule

### sv/rgf_queue.sv
// rgf_queue: two-entry FIFO between front and back.
// No dependencies.
module rgf_queue #(
    parameter int WIDTH = 8
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/rgf_back.sv
// rgf_back: walks the block column by column, accumulates the numerator,
// scales by the reciprocal and drives pixel writes. Depends on rgf_pkg, rgf_pix_if.
module rgf_back
    import rgf_pkg::*;
#(
    parameter int COORD_BITS = 12
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  rgf_desc_t             pop_desc,
    input  logic [COORD_BITS-1:0] pop_x0,
    input  logic [COORD_BITS-1:0] pop_y0,
    rgf_pix_if.source             pix
);

    localparam int PROD_W = RECIP_W + NUM_W;

    // walker
    logic                  busy_reg, busy_next;
    rgf_desc_t             desc_reg;
    logic [COORD_BITS-1:0] x0_reg, y0_reg;
    logic [EXT_W-1:0]      kx_reg, ky_reg, kx_next, ky_next;
    logic [NUM_W-1:0]      ncol_reg, ncur_reg, srow_reg;
    logic [NUM_W-1:0]      ncol_next, ncur_next, srow_next;

    // multiply stage
    logic                  a_valid_reg, a_valid_next;
    logic [COORD_BITS-1:0] a_x_reg, a_y_reg;
    logic [NUM_W-1:0]      a_num_reg;
    logic [RECIP_W-1:0]    a_recip_reg;
    logic                  a_ovr_reg, a_last_reg;
    logic [GRAY_W-1:0]     a_ovr_val_reg;

    // output stage
    logic                  o_valid_reg, o_valid_next;
    logic [COORD_BITS-1:0] o_x_reg, o_y_reg;
    logic [GRAY_W-1:0]     o_val_reg, o_val_next;
    logic                  o_last_reg;

    logic                  adv, at_last, load, step;
    logic                  ovr;
    logic [GRAY_W-1:0]     ovr_val;
    logic [PROD_W-1:0]     prod;

    assign adv       = !o_valid_reg || pix.ready;
    assign at_last   = (kx_reg == desc_reg.ext_x) && (ky_reg == desc_reg.ext_y);
    assign load      = adv && (!busy_reg || at_last) && pop_valid;
    assign step      = adv && busy_reg && !at_last;
    assign pop_ready = adv && (!busy_reg || at_last);

    // corner levels replace the formula, later corner winning
    always_comb
    begin
        ovr     = 1'b1;
        ovr_val = desc_reg.gray_a;
        priority if (kx_reg == desc_reg.ext_x && ky_reg == desc_reg.ext_y)
            ovr_val = desc_reg.gray_d;
        else if (kx_reg == '0 && ky_reg == desc_reg.ext_y)
            ovr_val = desc_reg.gray_c;
        else if (kx_reg == desc_reg.ext_x && ky_reg == '0)
            ovr_val = desc_reg.gray_b;
        else if (kx_reg == '0 && ky_reg == '0)
            ovr_val = desc_reg.gray_a;
        else
            ovr = 1'b0;
    end

    always_comb
    begin
        kx_next   = kx_reg;
        ky_next   = ky_reg;
        ncol_next = ncol_reg;
        ncur_next = ncur_reg;
        srow_next = srow_reg;
        if (load)
        begin
            kx_next   = '0;
            ky_next   = '0;
            ncol_next = pop_desc.num_base;
            ncur_next = pop_desc.num_base;
            srow_next = pop_desc.row_step;
        end
        else if (step)
        begin
            if (ky_reg == desc_reg.ext_y)
            begin
                kx_next   = kx_reg + EXT_W'(1);
                ky_next   = '0;
                ncol_next = ncol_reg + desc_reg.col_step;
                ncur_next = ncol_reg + desc_reg.col_step;
                srow_next = srow_reg + desc_reg.row_delta;
            end
            else
            begin
                ky_next   = ky_reg + EXT_W'(1);
                ncur_next = ncur_reg + srow_reg;
            end
        end
        busy_next    = adv ? ((busy_reg && !at_last) || load) : busy_reg;
        a_valid_next = adv ? busy_reg : a_valid_reg;
        o_valid_next = adv ? a_valid_reg : o_valid_reg;
    end

    assign prod       = {RECIP_W'(0), a_num_reg} * {NUM_W'(0), a_recip_reg};
    assign o_val_next = a_ovr_reg ? a_ovr_val_reg : prod[RECIP_SHIFT +: GRAY_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kx_reg   <= kx_next;
        ky_reg   <= ky_next;
        ncol_reg <= ncol_next;
        ncur_reg <= ncur_next;
        srow_reg <= srow_next;
        if (load)
        begin
            desc_reg <= pop_desc;
            x0_reg   <= pop_x0;
            y0_reg   <= pop_y0;
        end
        if (adv)
        begin
            a_x_reg       <= x0_reg + COORD_BITS'(kx_reg);
            a_y_reg       <= y0_reg + COORD_BITS'(ky_reg);
            a_num_reg     <= ncur_reg;
            a_recip_reg   <= desc_reg.recip;
            a_ovr_reg     <= ovr;
            a_ovr_val_reg <= ovr_val;
            a_last_reg    <= at_last;
            o_x_reg       <= a_x_reg;
            o_y_reg       <= a_y_reg;
            o_val_reg     <= o_val_next;
            o_last_reg    <= a_last_reg;
        end
    end

    assign pix.valid       = o_valid_reg;
    assign pix.pixel_x     = o_x_reg;
    assign pix.pixel_y     = o_y_reg;
    assign pix.pixel_value = o_val_reg;
    assign pix.last_pixel  = o_last_reg;

endmodule

### sv/rectangle_gradient_fill.sv
// rectangle_gradient_fill: top level, front -> queue -> back.
// Depends on rgf_pkg, rgf_blk_if, rgf_pix_if, rgf_front, rgf_queue, rgf_back.
//
//   channel  dir  transaction
//   blk      in   one block: kind, four gray levels, origin, extents
//   pix      out  one pixel write: x, y, value, last marker
//
// The back end emits one pixel per cycle unless pix stalls; the single pixel
// walker writes (ex+1)*(ey+1) pixels (1 to 64) per block of extents ex, ey.
// Path of a block: front register, queue, walker, multiply and output stages.
// Reset clears all valid and busy flags; no clearing pass.
// A stall on pix freezes the back end; the front end and a two-entry queue
// keep taking blocks until they fill.
module rectangle_gradient_fill
    import rgf_pkg::*;
#(
    parameter int MAX_EXTENT = 8,
    parameter int COORD_BITS = 12
)(
    input  logic      clk,
    input  logic      rst_n,
    rgf_blk_if.sink   blk,
    rgf_pix_if.source pix
);

    localparam int DESC_W  = $bits(rgf_desc_t);
    localparam int QUEUE_W = DESC_W + 2 * COORD_BITS;

    logic                  push_valid, push_ready;
    rgf_desc_t             push_desc;
    logic [COORD_BITS-1:0] push_x0, push_y0;
    logic                  pop_valid, pop_ready;
    logic [QUEUE_W-1:0]    pop_data;
    rgf_desc_t             pop_desc;
    logic [COORD_BITS-1:0] pop_x0, pop_y0;

    rgf_front #(
        .MAX_EXTENT (MAX_EXTENT),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk        (blk),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .push_x0    (push_x0),
        .push_y0    (push_y0)
    );

    rgf_queue #(
        .WIDTH (QUEUE_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_desc, push_x0, push_y0}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_desc = pop_data[QUEUE_W-1 -: DESC_W];
    assign pop_x0   = pop_data[2*COORD_BITS-1 -: COORD_BITS];
    assign pop_y0   = pop_data[COORD_BITS-1:0];

    rgf_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .pop_x0    (pop_x0),
        .pop_y0    (pop_y0),
        .pix       (pix)
    );

endmodule
